/* sv/complex_arithmetic_unit_top_macros.svh */
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle check
`define CAU_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("cau check failed");

// next-cycle check
`define CAU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("cau check failed");

`endif

/* sv/cau_pkg.sv */
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int QUO_W      = DATA_WIDTH + 1;
    localparam int REM_W      = PROD_W;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_EQ  = 3'd4,
        ACT_NE  = 3'd5
    } t_action;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] nlow;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_action                       act;
        logic signed [DATA_WIDTH-1:0]  res_re;
        logic signed [DATA_WIDTH-1:0]  res_im;
        logic                          cmp;
        logic                          sat;
        logic                          dz;
        logic                          neg_re;
        logic                          neg_im;
        logic                          ovf_re;
        logic                          ovf_im;
        logic [PROD_W-1:0]             den;
    } t_side;

    typedef struct packed {
        logic  valid;
        t_side side;
        t_lane re;
        t_lane im;
    } t_stage;

endpackage
`default_nettype wire

/* sv/cau_front.sv */
`default_nettype none
module cau_front (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_en,
    input  wire                                     i_valid,
    input  wire cau_pkg::t_action                   i_act,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_im,
    output cau_pkg::t_stage                         o_stage
);
    import cau_pkg::*;

    localparam logic signed [PROD_W:0] WMAX = (PROD_W+1)'(DMAX);
    localparam logic signed [PROD_W:0] WMIN = (PROD_W+1)'(DMIN);
    localparam logic signed [PROD_W:0] RND  = (PROD_W+1)'((1 << FRAC_BITS) - 1);
    localparam logic signed [PROD_W:0] ZERO = (PROD_W+1)'(0);

    function automatic logic [DATA_WIDTH:0] clip_w(input logic signed [PROD_W:0] v);
        logic [DATA_WIDTH:0] r;
        if (v > WMAX) begin
            r = {1'b1, DMAX};
        end else if (v < WMIN) begin
            r = {1'b1, DMIN};
        end else begin
            r = {1'b0, v[DATA_WIDTH-1:0]};
        end
        return r;
    endfunction

    logic                         r_s1_valid;
    t_action                      r_act;
    logic signed [DATA_WIDTH-1:0] r_a, r_b, r_c, r_d;
    logic signed [PROD_W-1:0]     r_ac, r_bd, r_ad, r_bc, r_cc, r_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act <= i_act;
            r_a   <= i_a_re;
            r_b   <= i_a_im;
            r_c   <= i_b_re;
            r_d   <= i_b_im;
            r_ac  <= PROD_W'(i_a_re) * PROD_W'(i_b_re);
            r_bd  <= PROD_W'(i_a_im) * PROD_W'(i_b_im);
            r_ad  <= PROD_W'(i_a_re) * PROD_W'(i_b_im);
            r_bc  <= PROD_W'(i_a_im) * PROD_W'(i_b_re);
            r_cc  <= PROD_W'(i_b_re) * PROD_W'(i_b_re);
            r_dd  <= PROD_W'(i_b_im) * PROD_W'(i_b_im);
        end
    end

    logic signed [PROD_W:0] w_add_re, w_add_im, w_sub_re, w_sub_im;
    logic signed [PROD_W:0] w_mul_re, w_mul_im, w_mtr_re, w_mtr_im;
    logic signed [PROD_W:0] w_nre, w_nim;
    logic [PROD_W-1:0]      w_mag_re, w_mag_im, w_den;
    logic [NUM_W-1:0]       w_num_re, w_num_im;
    logic [DATA_WIDTH:0]    w_cl_re, w_cl_im;
    t_side                  n_side;
    t_lane                  n_re, n_im;

    always_comb begin
        w_add_re = (PROD_W+1)'(r_a) + (PROD_W+1)'(r_c);
        w_add_im = (PROD_W+1)'(r_b) + (PROD_W+1)'(r_d);
        w_sub_re = (PROD_W+1)'(r_a) - (PROD_W+1)'(r_c);
        w_sub_im = (PROD_W+1)'(r_b) - (PROD_W+1)'(r_d);
        w_mul_re = (PROD_W+1)'(r_ac) - (PROD_W+1)'(r_bd);
        w_mul_im = (PROD_W+1)'(r_ad) + (PROD_W+1)'(r_bc);
        // truncate toward zero
        w_mtr_re = (w_mul_re + (w_mul_re[PROD_W] ? RND : ZERO)) >>> FRAC_BITS;
        w_mtr_im = (w_mul_im + (w_mul_im[PROD_W] ? RND : ZERO)) >>> FRAC_BITS;

        w_den    = $unsigned(r_cc) + $unsigned(r_dd);
        w_nre    = (PROD_W+1)'(r_ac) + (PROD_W+1)'(r_bd);
        w_nim    = (PROD_W+1)'(r_bc) - (PROD_W+1)'(r_ad);
        w_mag_re = PROD_W'(w_nre[PROD_W] ? -w_nre : w_nre);
        w_mag_im = PROD_W'(w_nim[PROD_W] ? -w_nim : w_nim);
        w_num_re = {w_mag_re, {FRAC_BITS{1'b0}}};
        w_num_im = {w_mag_im, {FRAC_BITS{1'b0}}};

        n_re.rem  = REM_W'(w_num_re[NUM_W-1:QUO_W]);
        n_re.nlow = w_num_re[QUO_W-1:0];
        n_re.quo  = '0;
        n_im.rem  = REM_W'(w_num_im[NUM_W-1:QUO_W]);
        n_im.nlow = w_num_im[QUO_W-1:0];
        n_im.quo  = '0;

        n_side        = '0;
        n_side.act    = r_act;
        n_side.den    = w_den;
        n_side.neg_re = w_nre[PROD_W];
        n_side.neg_im = w_nim[PROD_W];
        n_side.ovf_re = PROD_W'(w_num_re[NUM_W-1:QUO_W]) >= w_den;
        n_side.ovf_im = PROD_W'(w_num_im[NUM_W-1:QUO_W]) >= w_den;

        w_cl_re = '0;
        w_cl_im = '0;
        unique case (r_act)
            ACT_ADD: begin
                w_cl_re = clip_w(w_add_re);
                w_cl_im = clip_w(w_add_im);
            end
            ACT_SUB: begin
                w_cl_re = clip_w(w_sub_re);
                w_cl_im = clip_w(w_sub_im);
            end
            ACT_MUL: begin
                w_cl_re = clip_w(w_mtr_re);
                w_cl_im = clip_w(w_mtr_im);
            end
            ACT_DIV: begin
                if (w_den == '0) begin
                    n_side.dz = 1'b1;
                    w_cl_re   = {1'b0, DMAX};
                end
            end
            ACT_EQ:  n_side.cmp = (r_a == r_c) && (r_b == r_d);
            ACT_NE:  n_side.cmp = (r_a != r_c) || (r_b != r_d);
            default: n_side.cmp = 1'b0;
        endcase
        n_side.res_re = w_cl_re[DATA_WIDTH-1:0];
        n_side.res_im = w_cl_im[DATA_WIDTH-1:0];
        n_side.sat    = w_cl_re[DATA_WIDTH] | w_cl_im[DATA_WIDTH];
    end

    logic  r_valid;
    t_side r_side;
    t_lane r_re, r_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_re   <= n_re;
            r_im   <= n_im;
        end
    end

    assign o_stage = {r_valid, r_side, r_re, r_im};

endmodule
`default_nettype wire

/* sv/cau_div_cell.sv */
`default_nettype none
module cau_div_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire cau_pkg::t_stage i_stage,
    output cau_pkg::t_stage      o_stage
);
    import cau_pkg::*;

    function automatic t_lane div_step(input t_lane l, input logic [REM_W-1:0] den);
        logic [REM_W:0] sh;
        logic           ge;
        t_lane          n;
        sh     = {l.rem, l.nlow[QUO_W-1]};
        ge     = sh >= {1'b0, den};
        n.rem  = ge ? REM_W'(sh - {1'b0, den}) : REM_W'(sh);
        n.nlow = {l.nlow[QUO_W-2:0], 1'b0};
        n.quo  = {l.quo[QUO_W-2:0], ge};
        return n;
    endfunction

    logic  r_valid;
    t_side r_side;
    t_lane r_re, r_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_stage.side;
            r_re   <= div_step(i_stage.re, i_stage.side.den);
            r_im   <= div_step(i_stage.im, i_stage.side.den);
        end
    end

    assign o_stage = {r_valid, r_side, r_re, r_im};

endmodule
`default_nettype wire

/* sv/complex_arithmetic_unit_top.sv */
// channel   dir  tdata                                   tuser
// s_axis    in   a_re[15:0] a_im[31:16] b_re b_im [63:32] action[2:0]
// m_axis    out  res_re[15:0] res_im[31:16]              compare_true divide_by_zero saturated
//
// one transfer in and one out per cycle when the output is taken
// stages: 2 front stages, 17 divider cells, 1 output register
// the whole pipe advances while the output register is empty or being taken
// synchronous active-low reset clears the valid bits only
`default_nettype none
`include "complex_arithmetic_unit_top_macros.svh"
module complex_arithmetic_unit_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // a_re, a_im, b_re, b_im
    input  wire  [2:0]  i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // res_re, res_im
    output logic [2:0]  o_m_axis_tuser    // compare_true, divide_by_zero, saturated
);
    import cau_pkg::*;

    localparam logic [QUO_W-1:0] QLIM = QUO_W'(1) << (DATA_WIDTH - 1);

    function automatic logic [DATA_WIDTH:0] finish(input logic [QUO_W-1:0] q,
                                                   input logic neg, input logic ovf);
        logic [DATA_WIDTH:0] r;
        if (neg) begin
            if (ovf || q > QLIM) begin
                r = {1'b1, DMIN};
            end else begin
                r = {1'b0, DATA_WIDTH'(-q)};
            end
        end else begin
            if (ovf || q >= QLIM) begin
                r = {1'b1, DMAX};
            end else begin
                r = {1'b0, q[DATA_WIDTH-1:0]};
            end
        end
        return r;
    endfunction

    logic   w_en;
    t_stage w_chain [QUO_W+1];

    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_res_re, r_res_im;
    logic                         r_cmp, r_dz, r_sat;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_act   (t_action'(i_s_axis_tuser)),
        .i_a_re  (i_s_axis_tdata[15:0]),
        .i_a_im  (i_s_axis_tdata[31:16]),
        .i_b_re  (i_s_axis_tdata[47:32]),
        .i_b_im  (i_s_axis_tdata[63:48]),
        .o_stage (w_chain[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    t_stage              w_last;
    logic [DATA_WIDTH:0] w_fin_re, w_fin_im;
    logic                w_use_div;

    always_comb begin
        w_last    = w_chain[QUO_W];
        w_fin_re  = finish(w_last.re.quo, w_last.side.neg_re, w_last.side.ovf_re);
        w_fin_im  = finish(w_last.im.quo, w_last.side.neg_im, w_last.side.ovf_im);
        w_use_div = (w_last.side.act == ACT_DIV) && !w_last.side.dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmp <= w_last.side.cmp;
            r_dz  <= w_last.side.dz;
            if (w_use_div) begin
                r_res_re <= w_fin_re[DATA_WIDTH-1:0];
                r_res_im <= w_fin_im[DATA_WIDTH-1:0];
                r_sat    <= w_fin_re[DATA_WIDTH] | w_fin_im[DATA_WIDTH];
            end else begin
                r_res_re <= w_last.side.res_re;
                r_res_im <= w_last.side.res_im;
                r_sat    <= w_last.side.sat;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_res_im, r_res_re};
    assign o_m_axis_tuser  = {r_sat, r_dz, r_cmp};

    `CAU_ASSERT_NOW(a_dz_result, r_out_valid && r_dz, r_res_re == DMAX && r_res_im == '0 && !r_sat)
    `CAU_ASSERT_NOW(a_cmp_zero, r_out_valid && r_cmp, r_res_re == '0 && r_res_im == '0 && !r_dz)
    `CAU_ASSERT_NEXT(a_pipe_out, w_last.valid && w_en, r_out_valid)

endmodule
`default_nettype wire

/* verif/cau_checker.sv */
`default_nettype none
module cau_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [63:0] i_s_tdata,
    input  wire  [2:0]  i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,
    input  wire  [2:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import cau_pkg::*;

    typedef struct packed {
        logic [15:0] res_re;
        logic [15:0] res_im;
        logic        cmp;
        logic        dz;
        logic        sat;
    } t_result;

    t_result awaited_results[$];

    function automatic logic [15:0] saturate(longint v, inout logic sat);
        if (v > longint'(DMAX)) begin
            sat = 1'b1;
            return DMAX;
        end
        if (v < longint'(DMIN)) begin
            sat = 1'b1;
            return DMIN;
        end
        return v[15:0];
    endfunction

    function automatic t_result compute_complex(logic [2:0] act, logic [63:0] d);
        longint  ar, ai, br, bi, re, im, den;
        logic    arith;
        t_result r;
        ar = longint'($signed(d[15:0]));
        ai = longint'($signed(d[31:16]));
        br = longint'($signed(d[47:32]));
        bi = longint'($signed(d[63:48]));
        r = '0;
        re = 0;
        im = 0;
        arith = 1'b1;
        case (act)
            ACT_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            ACT_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            ACT_MUL: begin
                re = (ar * br - ai * bi) / 256;
                im = (ar * bi + ai * br) / 256;
            end
            ACT_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    arith = 1'b0;
                    r.dz = 1'b1;
                    r.res_re = DMAX;
                end else begin
                    re = ((ar * br + ai * bi) * 256) / den;
                    im = ((ai * br - ar * bi) * 256) / den;
                end
            end
            ACT_EQ: begin
                arith = 1'b0;
                r.cmp = (ar == br) && (ai == bi);
            end
            ACT_NE: begin
                arith = 1'b0;
                r.cmp = (ar != br) || (ai != bi);
            end
            default: arith = 1'b0;
        endcase
        if (arith) begin
            r.res_re = saturate(re, r.sat);
            r.res_im = saturate(im, r.sat);
        end
        return r;
    endfunction

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        t_result e;
        t_result got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(compute_complex(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[15:0], i_m_tdata[31:16], i_m_tuser[0], i_m_tuser[1],
                    i_m_tuser[2]};
                if (awaited_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = awaited_results.pop_front();
                    if (e != got) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: exp re %h im %h cmp %b dz %b sat %b, ",
                                      "got re %h im %h cmp %b dz %b sat %b"},
                                e.res_re, e.res_im, e.cmp, e.dz, e.sat,
                                got.res_re, got.res_im, got.cmp, got.dz, got.sat);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

/* verif/tb_complex_arithmetic_unit_top.sv */
`default_nettype none
module tb_complex_arithmetic_unit_top;
    import cau_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    complex_arithmetic_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    cau_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

    function automatic logic [15:0] pick_part();
        case ($urandom_range(7, 0))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(1024, 0)) - 512);
            4: return 16'($signed($urandom_range(8192, 0)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [2:0] act, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {bi, br, ai, ar};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_item();
        logic [15:0] ar, ai, br, bi;
        logic [2:0]  act;
        ar = pick_part();
        ai = pick_part();
        br = pick_part();
        bi = pick_part();
        act = 3'($urandom_range(7, 0));
        if (act == ACT_DIV && $urandom_range(9, 0) == 0) begin
            br = '0;
            bi = '0;
        end
        if ((act == ACT_EQ || act == ACT_NE) && $urandom_range(1, 0)) begin
            br = ar;
            bi = ai;
            if ($urandom_range(2, 0) == 0) bi[$urandom_range(15, 0)] ^= 1'b1;
        end
        send_item(act, ar, ai, br, bi);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_item(ACT_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
        send_item(ACT_ADD, 16'h1234, 16'hff00, 16'h0100, 16'h0200);
        send_item(ACT_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
        send_item(ACT_SUB, 16'h0300, 16'h0100, 16'h0100, 16'h0300);
        send_item(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(ACT_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_item(ACT_MUL, 16'hff80, 16'h0080, 16'h0001, 16'h0003);
        send_item(ACT_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
        send_item(ACT_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_item(ACT_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        send_item(ACT_DIV, 16'h0100, 16'h0000, 16'h8000, 16'h8000);
        send_item(ACT_DIV, 16'hff01, 16'h0300, 16'h0300, 16'hfd00);
        send_item(ACT_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
        send_item(ACT_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
        send_item(ACT_NE, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
        send_item(ACT_NE, 16'h7fff, 16'h0000, 16'hffff, 16'h0000);
        send_item(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        send_item(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // hold off until everything is back
        drain();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 38; recv_stall_pct = 38; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (380) random_item();
        end
        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div_cell.sv
sv/complex_arithmetic_unit_top.sv
verif/cau_checker.sv
verif/tb_complex_arithmetic_unit_top.sv
